// ===== rtl/core/wcst_pkg.sv =====
// Shared types, operation and status codes, and digit helpers for the wall clock.
package wcst_pkg;

  // Operation codes of an input beat
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_RESET = 3'd2;
  localparam logic [2:0] OP_SET   = 3'd3;

  // Status codes of a result beat
  localparam logic [3:0] ST_ACCEPTED     = 4'd0;
  localparam logic [3:0] ST_TICK_SHOWN   = 4'd1;
  localparam logic [3:0] ST_TICK_IGNORED = 4'd2;
  localparam logic [3:0] ST_STOP_ARGS    = 4'd3;
  localparam logic [3:0] ST_RESET_ARGS   = 4'd4;
  localparam logic [3:0] ST_SET_EMPTY    = 4'd5;
  localparam logic [3:0] ST_BAD_FORMAT   = 4'd6;
  localparam logic [3:0] ST_BAD_HOURS    = 4'd7;
  localparam logic [3:0] ST_BAD_MINUTES  = 4'd8;
  localparam logic [3:0] ST_BAD_SECONDS  = 4'd9;
  localparam logic [3:0] ST_TRAILING     = 4'd10;
  localparam logic [3:0] ST_UNKNOWN      = 4'd11;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Input beat payload
  typedef struct packed {
    logic [2:0] operation;
    logic       has_arguments;
    logic       trailing_text;
    logic [7:0] hour_tens_char;
    logic [7:0] hour_ones_char;
    logic [7:0] first_separator_char;
    logic [7:0] minute_tens_char;
    logic [7:0] minute_ones_char;
    logic [7:0] second_separator_char;
    logic [7:0] second_tens_char;
    logic [7:0] second_ones_char;
  } in_item_t;

  // Result beat payload
  typedef struct packed {
    logic [3:0] status;
    logic [5:0] out_hour_tens;
    logic [5:0] out_hour_ones;
    logic [5:0] out_minute_tens;
    logic [5:0] out_minute_ones;
    logic [5:0] out_second_tens;
    logic [5:0] out_second_ones;
  } out_item_t;

  // Time of day held as BCD digits; equals seconds of day mod 86400
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } clock_time_t;

  // Next state and status from the execute logic
  typedef struct packed {
    logic [3:0]  status;
    clock_time_t time_nxt;
    logic        running_nxt;
  } exec_result_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Digit 0..9 to its ASCII code, kept to six bits
  function automatic logic [5:0] to_ascii(logic [3:0] d);
    return {2'b11, d};
  endfunction

endpackage

// ===== rtl/core/wcst_in_if.sv =====
// Valid/ready channel carrying input beats.
interface wcst_in_if;
  import wcst_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/wcst_out_if.sv =====
// Valid/ready channel carrying result beats.
interface wcst_out_if;
  import wcst_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/wall_clock_set_and_tick.sv =====
// Wall clock top level: input register, execute logic, result register.
// Flow: an accepted beat is registered, executed from the input register and
// its result is held in the result register that drives the result channel.
// Throughput: one beat per cycle while the result channel is not stalled; the
// time and running state update in the execute cycle, so each beat sees the state left by the one before it.
// Reset: pipeline empty, time 00:00:00, clock stopped.
module wall_clock_set_and_tick (
  input  logic            clk,
  input  logic            rst_n,
  wcst_in_if.sink         in_ch,
  wcst_out_if.source      out_ch
);
  import wcst_pkg::*;

  logic         s1_valid_r;
  in_item_t     s1_item_r;
  logic         out_valid_r;
  out_item_t    out_item_r;
  clock_time_t  time_r;
  logic         running_r;
  exec_result_t exec_res;
  logic         advance;
  logic         exec_fire;

  // Result register frees up when empty or when its beat is taken
  assign advance   = !out_valid_r || out_ch.ready;
  assign exec_fire = advance && s1_valid_r;
  assign in_ch.ready = !s1_valid_r || advance;

  wcst_exec u_exec (
    .item     (s1_item_r),
    .cur_time (time_r),
    .running  (running_r),
    .res      (exec_res)
  );

  // Control and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      time_r      <= '0;
      running_r   <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (exec_fire) begin
        time_r    <= exec_res.time_nxt;
        running_r <= exec_res.running_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.data;
    end
    if (exec_fire) begin
      out_item_r.status          <= exec_res.status;
      out_item_r.out_hour_tens   <= to_ascii({2'b00, exec_res.time_nxt.hour_tens});
      out_item_r.out_hour_ones   <= to_ascii(exec_res.time_nxt.hour_ones);
      out_item_r.out_minute_tens <= to_ascii({1'b0, exec_res.time_nxt.minute_tens});
      out_item_r.out_minute_ones <= to_ascii(exec_res.time_nxt.minute_ones);
      out_item_r.out_second_tens <= to_ascii({1'b0, exec_res.time_nxt.second_tens});
      out_item_r.out_second_ones <= to_ascii(exec_res.time_nxt.second_ones);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // Held time is always a legal time of day
  a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.second_ones <= 4'd9) && (time_r.second_tens <= 3'd5) &&
    (time_r.minute_ones <= 4'd9) && (time_r.minute_tens <= 3'd5) &&
    ((time_r.hour_tens < 2'd2 && time_r.hour_ones <= 4'd9) ||
     (time_r.hour_tens == 2'd2 && time_r.hour_ones <= 4'd3)))
    else $error("clock time out of range");

  // A stalled result beat freezes the clock state
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> ($stable(time_r) && $stable(running_r)))
    else $error("state changed while result stalled");

  // A tick with the clock stopped leaves the time alone
  a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && s1_item_r.operation == OP_TICK && !running_r) |=> $stable(time_r))
    else $error("time moved on a stopped tick");

endmodule

// ===== rtl/core/wcst_exec.sv =====
// Command decode, set-time checks and BCD time advance for one beat.
module wcst_exec (
  input  wcst_pkg::in_item_t     item,
  input  wcst_pkg::clock_time_t  cur_time,
  input  logic                   running,
  output wcst_pkg::exec_result_t res
);
  import wcst_pkg::*;

  clock_time_t tick_time;
  clock_time_t set_time;
  logic        fmt_ok;
  logic        hours_ok;
  logic        minutes_ok;
  logic        seconds_ok;
  logic [3:0]  set_status;

  // One-second advance with carries through the digit chain
  always_comb begin
    tick_time = cur_time;
    if (cur_time.second_ones != 4'd9) begin
      tick_time.second_ones = cur_time.second_ones + 4'd1;
    end else begin
      tick_time.second_ones = '0;
      if (cur_time.second_tens != 3'd5) begin
        tick_time.second_tens = cur_time.second_tens + 3'd1;
      end else begin
        tick_time.second_tens = '0;
        if (cur_time.minute_ones != 4'd9) begin
          tick_time.minute_ones = cur_time.minute_ones + 4'd1;
        end else begin
          tick_time.minute_ones = '0;
          if (cur_time.minute_tens != 3'd5) begin
            tick_time.minute_tens = cur_time.minute_tens + 3'd1;
          end else begin
            tick_time.minute_tens = '0;
            // 23:59:59 wraps to midnight
            if (cur_time.hour_tens == 2'd2 && cur_time.hour_ones == 4'd3) begin
              tick_time.hour_tens = '0;
              tick_time.hour_ones = '0;
            end else if (cur_time.hour_ones == 4'd9) begin
              tick_time.hour_tens = cur_time.hour_tens + 2'd1;
              tick_time.hour_ones = '0;
            end else begin
              tick_time.hour_ones = cur_time.hour_ones + 4'd1;
            end
          end
        end
      end
    end
  end

  // Set-time checks, first failure wins
  assign fmt_ok = is_digit(item.hour_tens_char) && is_digit(item.hour_ones_char) &&
                  (item.first_separator_char == CHAR_COLON) &&
                  is_digit(item.minute_tens_char) && is_digit(item.minute_ones_char) &&
                  (item.second_separator_char == CHAR_COLON) &&
                  is_digit(item.second_tens_char) && is_digit(item.second_ones_char);
  assign hours_ok   = (item.hour_tens_char[3:0] < 4'd2) ||
                      ((item.hour_tens_char[3:0] == 4'd2) &&
                       (item.hour_ones_char[3:0] <= 4'd3));
  assign minutes_ok = item.minute_tens_char[3:0] <= 4'd5;
  assign seconds_ok = item.second_tens_char[3:0] <= 4'd5;

  always_comb begin
    priority if (!item.has_arguments) begin
      set_status = ST_SET_EMPTY;
    end else if (!fmt_ok) begin
      set_status = ST_BAD_FORMAT;
    end else if (!hours_ok) begin
      set_status = ST_BAD_HOURS;
    end else if (!minutes_ok) begin
      set_status = ST_BAD_MINUTES;
    end else if (!seconds_ok) begin
      set_status = ST_BAD_SECONDS;
    end else if (item.trailing_text) begin
      set_status = ST_TRAILING;
    end else begin
      set_status = ST_ACCEPTED;
    end
  end

  // Digits of a well-formed time fit the narrow fields
  assign set_time.hour_tens   = item.hour_tens_char[1:0];
  assign set_time.hour_ones   = item.hour_ones_char[3:0];
  assign set_time.minute_tens = item.minute_tens_char[2:0];
  assign set_time.minute_ones = item.minute_ones_char[3:0];
  assign set_time.second_tens = item.second_tens_char[2:0];
  assign set_time.second_ones = item.second_ones_char[3:0];

  // Per-operation status and state update
  always_comb begin
    res.status      = ST_UNKNOWN;
    res.time_nxt    = cur_time;
    res.running_nxt = running;
    unique case (item.operation)
      OP_TICK: begin
        if (running) begin
          res.time_nxt = tick_time;
          res.status   = ST_TICK_SHOWN;
        end else begin
          res.status = ST_TICK_IGNORED;
        end
      end
      OP_STOP: begin
        if (item.has_arguments) begin
          res.status = ST_STOP_ARGS;
        end else begin
          res.running_nxt = 1'b0;
          res.status      = ST_ACCEPTED;
        end
      end
      OP_RESET: begin
        if (item.has_arguments) begin
          res.status = ST_RESET_ARGS;
        end else begin
          res.time_nxt    = '0;
          res.running_nxt = 1'b1;
          res.status      = ST_ACCEPTED;
        end
      end
      OP_SET: begin
        res.status = set_status;
        if (set_status == ST_ACCEPTED) begin
          res.time_nxt    = set_time;
          res.running_nxt = 1'b1;
        end
      end
      default: begin
        res.status = ST_UNKNOWN;
      end
    endcase
  end

endmodule

// ===== tb/wall_clock_check_pkg.sv =====
`timescale 1ns / 1ps
// Readout predictor and scoreboard class for the wall clock testbench.
package wall_clock_check_pkg;
  import wcst_pkg::*;

  // Codes 4..7 have no command behind them
  localparam logic [2:0] OP_UNKNOWN = 3'd4;
  localparam logic [2:0] OP_LAST    = 3'd7;

  localparam int SECONDS_PER_DAY = 24 * 60 * 60;
  localparam int HOUR_MAX        = 23;
  localparam int MIN_SEC_MAX     = 59;
  localparam int REPORT_LIMIT    = 10;

  class clock_scoreboard;
    logic [16:0] day_seconds;
    bit          running;
    out_item_t   expected_readouts[$];
    int          failures;

    function new();
      day_seconds = '0;
      running     = 1'b0;
      failures    = 0;
    endfunction

    function bit char_is_digit(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function int char_value(logic [7:0] c);
      return int'(c) - int'(CHAR_ZERO);
    endfunction

    function logic [5:0] ascii_digit(int d);
      return 6'(int'(CHAR_ZERO) + d);
    endfunction

    // Set checks run empty arguments, format, hours, minutes, seconds, trailing text;
    // the time loads only if all of them pass
    function logic [3:0] apply_set(in_item_t cmd);
      int hours;
      int minutes;
      int secs;
      if (!cmd.has_arguments) return ST_SET_EMPTY;
      if (!(char_is_digit(cmd.hour_tens_char) && char_is_digit(cmd.hour_ones_char) &&
            cmd.first_separator_char == CHAR_COLON &&
            char_is_digit(cmd.minute_tens_char) && char_is_digit(cmd.minute_ones_char) &&
            cmd.second_separator_char == CHAR_COLON &&
            char_is_digit(cmd.second_tens_char) && char_is_digit(cmd.second_ones_char)))
        return ST_BAD_FORMAT;
      hours = char_value(cmd.hour_tens_char) * 10 + char_value(cmd.hour_ones_char);
      if (hours > HOUR_MAX) return ST_BAD_HOURS;
      minutes = char_value(cmd.minute_tens_char) * 10 + char_value(cmd.minute_ones_char);
      if (minutes > MIN_SEC_MAX) return ST_BAD_MINUTES;
      secs = char_value(cmd.second_tens_char) * 10 + char_value(cmd.second_ones_char);
      if (secs > MIN_SEC_MAX) return ST_BAD_SECONDS;
      if (cmd.trailing_text) return ST_TRAILING;
      day_seconds = 17'(hours * 3600 + minutes * 60 + secs);
      running     = 1'b1;
      return ST_ACCEPTED;
    endfunction

    // Update the clock for one accepted input beat and queue its readout
    function void note_command(in_item_t cmd);
      out_item_t readout;
      int        t;
      case (cmd.operation)
        OP_TICK: begin
          if (running) begin
            day_seconds    = 17'((int'(day_seconds) + 1) % SECONDS_PER_DAY);
            readout.status = ST_TICK_SHOWN;
          end else begin
            readout.status = ST_TICK_IGNORED;
          end
        end
        OP_STOP: begin
          if (cmd.has_arguments) begin
            readout.status = ST_STOP_ARGS;
          end else begin
            running        = 1'b0;
            readout.status = ST_ACCEPTED;
          end
        end
        OP_RESET: begin
          if (cmd.has_arguments) begin
            readout.status = ST_RESET_ARGS;
          end else begin
            day_seconds    = '0;
            running        = 1'b1;
            readout.status = ST_ACCEPTED;
          end
        end
        OP_SET: readout.status = apply_set(cmd);
        default: readout.status = ST_UNKNOWN;
      endcase

      // Every readout shows the time after the update
      t = int'(day_seconds);
      readout.out_hour_tens   = ascii_digit((t / 3600) / 10);
      readout.out_hour_ones   = ascii_digit((t / 3600) % 10);
      readout.out_minute_tens = ascii_digit(((t / 60) % 60) / 10);
      readout.out_minute_ones = ascii_digit(((t / 60) % 60) % 10);
      readout.out_second_tens = ascii_digit((t % 60) / 10);
      readout.out_second_ones = ascii_digit((t % 60) % 10);
      expected_readouts.push_back(readout);
    endfunction

    function void report_field(string field, int want, int got);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("readout mismatch in %s: expected %0d, got %0d", field, want, got);
    endfunction

    // Compare one result beat with the oldest queued readout
    function void check_readout(out_item_t got);
      out_item_t want;
      if (expected_readouts.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("readout with none pending: status %0d", got.status);
        return;
      end
      want = expected_readouts.pop_front();
      if (got.status !== want.status)
        report_field("status", want.status, got.status);
      if (got.out_hour_tens !== want.out_hour_tens)
        report_field("hour tens", want.out_hour_tens, got.out_hour_tens);
      if (got.out_hour_ones !== want.out_hour_ones)
        report_field("hour ones", want.out_hour_ones, got.out_hour_ones);
      if (got.out_minute_tens !== want.out_minute_tens)
        report_field("minute tens", want.out_minute_tens, got.out_minute_tens);
      if (got.out_minute_ones !== want.out_minute_ones)
        report_field("minute ones", want.out_minute_ones, got.out_minute_ones);
      if (got.out_second_tens !== want.out_second_tens)
        report_field("second tens", want.out_second_tens, got.out_second_tens);
      if (got.out_second_ones !== want.out_second_ones)
        report_field("second ones", want.out_second_ones, got.out_second_ones);
    endfunction

    function bit drained();
      return expected_readouts.size() == 0;
    endfunction

    function void close_out();
      if (expected_readouts.size() != 0) begin
        failures += expected_readouts.size();
        $display("%0d readouts never arrived", expected_readouts.size());
      end
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top-level testbench for the wall clock: stimulus, handshakes and checking.
module testbench;
  import wcst_pkg::*;
  import wall_clock_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD_OFF  = 400;
  localparam int PHASE_ITEMS    = 175;

  // Ways a random set command gets broken
  typedef enum int {
    FAULT_NONE,
    FAULT_HOURS,
    FAULT_MINUTES,
    FAULT_SECONDS,
    FAULT_TRAILING,
    FAULT_FORMAT
  } set_fault_e;

  logic clk;
  logic rst_n;

  wcst_in_if  in_ch ();
  wcst_out_if out_ch ();

  wall_clock_set_and_tick dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  clock_scoreboard readouts = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_req  = 0;
  int quiet_cycles  = 0;

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random back-pressure plus a long hold-off when requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watch both channels; values seen here are the ones before the edge
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) readouts.note_command(in_ch.data);
    if (out_ch.valid && out_ch.ready) readouts.check_readout(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: too long without any beat
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Command with random payload; fields the operation ignores stay random
  function automatic in_item_t random_cmd(logic [2:0] op);
    logic [95:0] raw;
    in_item_t    cmd;
    raw = {$urandom, $urandom, $urandom};
    cmd = raw[$bits(in_item_t)-1:0];
    cmd.operation = op;
    return cmd;
  endfunction

  function automatic in_item_t plain_cmd(logic [2:0] op, bit args);
    in_item_t cmd;
    cmd = random_cmd(op);
    cmd.has_arguments = args;
    return cmd;
  endfunction

  // Set command hh:mm:ss; values above 99 are never asked for
  function automatic in_item_t set_cmd(int hours, int minutes, int secs, bit trailing);
    in_item_t cmd;
    cmd = random_cmd(OP_SET);
    cmd.has_arguments         = 1'b1;
    cmd.trailing_text         = trailing;
    cmd.hour_tens_char        = CHAR_ZERO + 8'(hours / 10);
    cmd.hour_ones_char        = CHAR_ZERO + 8'(hours % 10);
    cmd.first_separator_char  = CHAR_COLON;
    cmd.minute_tens_char      = CHAR_ZERO + 8'(minutes / 10);
    cmd.minute_ones_char      = CHAR_ZERO + 8'(minutes % 10);
    cmd.second_separator_char = CHAR_COLON;
    cmd.second_tens_char      = CHAR_ZERO + 8'(secs / 10);
    cmd.second_ones_char      = CHAR_ZERO + 8'(secs % 10);
    return cmd;
  endfunction

  // Mostly well-formed sets biased toward rollover points, some broken
  function automatic in_item_t random_set();
    in_item_t   cmd;
    set_fault_e fault;
    int         hours;
    int         minutes;
    int         secs;
    int         pos;
    logic [7:0] bad;
    bit         colon_pos;
    hours   = ($urandom_range(0, 3) == 0) ? HOUR_MAX : $urandom_range(0, HOUR_MAX);
    minutes = ($urandom_range(0, 1) == 0) ? MIN_SEC_MAX : $urandom_range(0, MIN_SEC_MAX);
    secs    = ($urandom_range(0, 1) == 0) ? $urandom_range(MIN_SEC_MAX - 4, MIN_SEC_MAX)
                                          : $urandom_range(0, MIN_SEC_MAX);
    if ($urandom_range(0, 9) < 6) begin
      fault = FAULT_NONE;
    end else begin
      fault = set_fault_e'($urandom_range(FAULT_HOURS, FAULT_FORMAT));
    end
    case (fault)
      FAULT_HOURS:   hours   = $urandom_range(HOUR_MAX + 1, 99);
      FAULT_MINUTES: minutes = $urandom_range(MIN_SEC_MAX + 1, 99);
      FAULT_SECONDS: secs    = $urandom_range(MIN_SEC_MAX + 1, 99);
      default: ;
    endcase
    cmd = set_cmd(hours, minutes, secs, fault == FAULT_TRAILING);

    // One bad character: a neighbor of the legal range or any other byte
    if (fault == FAULT_FORMAT) begin
      pos       = $urandom_range(0, 7);
      colon_pos = (pos == 2) || (pos == 5);
      if (colon_pos) begin
        bad = ($urandom_range(0, 1) == 0) ? CHAR_COLON - 8'd1 : CHAR_COLON + 8'd1;
      end else begin
        bad = ($urandom_range(0, 1) == 0) ? CHAR_ZERO - 8'd1 : CHAR_NINE + 8'd1;
      end
      if ($urandom_range(0, 1) == 0) begin
        do bad = 8'($urandom);
        while (colon_pos ? (bad == CHAR_COLON) : (bad >= CHAR_ZERO && bad <= CHAR_NINE));
      end
      case (pos)
        0: cmd.hour_tens_char        = bad;
        1: cmd.hour_ones_char        = bad;
        2: cmd.first_separator_char  = bad;
        3: cmd.minute_tens_char      = bad;
        4: cmd.minute_ones_char      = bad;
        5: cmd.second_separator_char = bad;
        6: cmd.second_tens_char      = bad;
        default: cmd.second_ones_char = bad;
      endcase
    end
    if ($urandom_range(0, 19) == 0) cmd.has_arguments = 1'b0;
    return cmd;
  endfunction

  // Ticks dominate so the time actually runs; commands mix in between
  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return random_cmd(OP_TICK);
    if (pick < 51) return plain_cmd(OP_STOP, $urandom_range(0, 2) == 0);
    if (pick < 57) return plain_cmd(OP_RESET, $urandom_range(0, 2) == 0);
    if (pick < 88) return random_set();
    return random_cmd(3'($urandom_range(OP_UNKNOWN, OP_LAST)));
  endfunction

  // Offer one beat, with random idle cycles first, and wait until taken
  task automatic send_beat(input in_item_t cmd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= cmd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait for every pending readout
  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (!readouts.drained()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_beat(random_item());
  endtask

  task automatic run_directed();
    in_item_t cmd;
    // Error paths out of reset, clock stopped
    send_beat(plain_cmd(OP_TICK, 1'b0));
    send_beat(plain_cmd(OP_STOP, 1'b1));
    send_beat(plain_cmd(OP_RESET, 1'b1));
    cmd = set_cmd(12, 34, 56, 1'b0);
    cmd.has_arguments = 1'b0;
    send_beat(cmd);
    send_beat(plain_cmd(OP_UNKNOWN, 1'b0));
    send_beat(plain_cmd(OP_LAST, 1'b1));
    // Last second of the day, then wrap past midnight
    send_beat(set_cmd(HOUR_MAX, MIN_SEC_MAX, MIN_SEC_MAX, 1'b0));
    send_beat(plain_cmd(OP_TICK, 1'b0));
    send_beat(plain_cmd(OP_TICK, 1'b1));
    // Format errors at the edges of the digit and colon ranges
    cmd = set_cmd(12, 34, 56, 1'b0);
    cmd.first_separator_char = CHAR_ZERO - 8'd1;
    send_beat(cmd);
    cmd = set_cmd(12, 34, 56, 1'b0);
    cmd.second_ones_char = CHAR_NINE + 8'd1;
    send_beat(cmd);
    cmd = set_cmd(12, 34, 56, 1'b0);
    cmd.hour_tens_char   = 8'hFF;
    cmd.minute_ones_char = 8'h00;
    send_beat(cmd);
    // Range errors and the order of the checks
    send_beat(set_cmd(HOUR_MAX + 1, 0, 0, 1'b0));
    send_beat(set_cmd(0, MIN_SEC_MAX + 1, 0, 1'b0));
    send_beat(set_cmd(0, 0, MIN_SEC_MAX + 1, 1'b0));
    send_beat(set_cmd(0, 0, 0, 1'b1));
    send_beat(set_cmd(99, 99, 99, 1'b1));
    cmd = set_cmd(99, 0, 0, 1'b0);
    cmd.second_separator_char = CHAR_COLON + 8'd1;
    send_beat(cmd);
    // Hour carry
    send_beat(set_cmd(9, MIN_SEC_MAX, MIN_SEC_MAX, 1'b0));
    send_beat(plain_cmd(OP_TICK, 1'b0));
    // Stop, ignored tick, reset while stopped and while running
    send_beat(plain_cmd(OP_STOP, 1'b0));
    send_beat(plain_cmd(OP_TICK, 1'b0));
    send_beat(plain_cmd(OP_RESET, 1'b0));
    send_beat(plain_cmd(OP_TICK, 1'b0));
    send_beat(plain_cmd(OP_RESET, 1'b0));
    send_beat(set_cmd(0, 0, 0, 1'b0));
    send_beat(plain_cmd(OP_TICK, 1'b0));
  endtask

  // Main sequence
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles lightly, receiver heavily; long hold-off to fill the block
    send_idle_pct = 26;
    recv_idle_pct = 69;
    run_directed();
    hold_off_req = LONG_HOLD_OFF;
    run_random(PHASE_ITEMS);
    pause_sender();

    // Roles swapped
    send_idle_pct = 69;
    recv_idle_pct = 26;
    run_random(PHASE_ITEMS);
    pause_sender();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    pause_sender();

    readouts.close_out();
    if (readouts.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wcst_pkg.sv
rtl/core/wcst_in_if.sv
rtl/core/wcst_out_if.sv
rtl/core/wcst_exec.sv
rtl/core/wall_clock_set_and_tick.sv
tb/wall_clock_check_pkg.sv
tb/testbench.sv
